FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rvx_pkg.sv
// shared types and constants of the execute unit
package rvx_pkg;

  localparam int XLEN = 32;
  localparam int DIV_CELLS = XLEN;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL = 32'h0000_0073;
  localparam logic [31:0] WORD_URET  = 32'h0020_0073;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] SYS_NONE  = 2'd0;
  localparam logic [1:0] SYS_ECALL = 2'd1;
  localparam logic [1:0] SYS_URET  = 2'd2;
  localparam logic [1:0] SYS_OTHER = 2'd3;

  // how the final value is picked once the long units finish
  typedef enum logic [2:0] {
    SEL_DIRECT = 3'd0,
    SEL_MUL_LO = 3'd1,
    SEL_MUL_HI = 3'd2,
    SEL_QUOT   = 3'd3,
    SEL_REM    = 3'd4
  } val_sel_t;

  // everything that travels beside the divider chain
  typedef struct packed {
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] npc;
    logic [1:0]  mkind;
    logic [2:0]  mwidth;
    logic [31:0] maddr;
    logic [31:0] sdata;
    logic        ill;
    logic [1:0]  sys;
    val_sel_t    sel;
    logic        neg_q;
    logic        neg_r;
    logic        dzero;
    logic        ovf;
    logic [31:0] a;
    logic        hsub_a;
    logic        hsub_b;
    logic [31:0] b;
  } side_t;

  // one divider cell's payload
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } div_t;

endpackage

FILE: rtl/core/rvx_decode.sv
// decode and direct results of one instruction
module rvx_decode (
  input  logic [31:0]    instruction,
  input  logic [31:0]    pc,
  input  logic [31:0]    rs1_value,
  input  logic [31:0]    rs2_value,
  input  logic [31:0]    return_pc,
  output rvx_pkg::side_t side,
  output rvx_pkg::div_t  div_in
);
  import rvx_pkg::*;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immj, a, b, sum_i, npc4;
  logic [4:0]  sh;
  logic        brc, ill, wr;
  logic [31:0] ua, ub;
  logic        na, nb;

  assign a = rs1_value;
  assign b = rs2_value;
  assign op = instruction[6:0];
  assign f3 = instruction[14:12];
  assign f7 = instruction[31:25];
  assign immi = {{20{instruction[31]}}, instruction[31:20]};
  assign imms = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign immb = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                 instruction[11:8], 1'b0};
  assign immj = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                 instruction[30:21], 1'b0};
  assign sum_i = a + immi;
  assign npc4 = pc + 32'd4;
  assign na = a[31];
  assign nb = b[31];

  // main decode
  always_comb begin
    side = '0;
    side.sel = SEL_DIRECT;
    side.rd = instruction[11:7];
    side.npc = npc4;
    side.a = a;
    side.b = b;
    ill = 1'b0;
    wr = 1'b0;
    brc = 1'b0;
    sh = 5'd0;
    ua = a;
    ub = b;
    case (op)
      OP_LUI: begin
        side.val = {instruction[31:12], 12'd0};
        wr = 1'b1;
      end
      OP_AUIPC: begin
        side.val = pc + {instruction[31:12], 12'd0};
        wr = 1'b1;
      end
      OP_JAL: begin
        side.val = npc4;
        wr = 1'b1;
        side.npc = pc + immj;
      end
      OP_JALR: begin
        if (f3 != 3'd0) ill = 1'b1;
        else begin
          side.val = npc4;
          wr = 1'b1;
          side.npc = {sum_i[31:1], 1'b0};
        end
      end
      OP_BRANCH: begin
        case (f3[2:1])
          2'd0: brc = (a == b);
          2'd2: brc = ($signed(a) < $signed(b));
          2'd3: brc = (a < b);
          default: ill = 1'b1;
        endcase
        if (f3[0]) brc = !brc;
        if (brc && !ill) side.npc = pc + immb;
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) ill = 1'b1;
        else begin
          side.mkind = MEM_LOAD;
          side.mwidth = f3;
          side.maddr = sum_i;
          wr = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 > 3'd2) ill = 1'b1;
        else begin
          side.mkind = MEM_STORE;
          side.mwidth = f3;
          side.sdata = b;
          side.maddr = a + imms;
        end
      end
      OP_IMM: begin
        sh = immi[4:0];
        case (f3)
          3'd0: side.val = sum_i;
          3'd1: begin
            if (f7 != 7'd0) ill = 1'b1;
            else side.val = a << sh;
          end
          3'd2: side.val = {31'd0, $signed(a) < $signed(immi)};
          3'd3: side.val = {31'd0, a < immi};
          3'd4: side.val = a ^ immi;
          3'd5: begin
            if (f7 == 7'd0) side.val = a >> sh;
            else if (f7 == 7'h20) side.val = $unsigned($signed(a) >>> sh);
            else ill = 1'b1;
          end
          3'd6: side.val = a | immi;
          default: side.val = a & immi;
        endcase
        wr = !ill;
      end
      OP_REG: begin
        sh = b[4:0];
        if (f7 == 7'd1) begin
          case (f3)
            3'd0: side.sel = SEL_MUL_LO;
            3'd1: begin
              side.sel = SEL_MUL_HI;
              side.hsub_a = na;
              side.hsub_b = nb;
            end
            3'd2: begin
              side.sel = SEL_MUL_HI;
              side.hsub_a = na;
            end
            3'd3: side.sel = SEL_MUL_HI;
            3'd4, 3'd6: begin
              side.sel = f3[1] ? SEL_REM : SEL_QUOT;
              ua = na ? -a : a;
              ub = nb ? -b : b;
              side.neg_q = na ^ nb;
              side.neg_r = na;
              side.dzero = (b == 32'd0);
              side.ovf = (a == 32'h8000_0000) && (b == 32'hffff_ffff);
            end
            default: begin
              side.sel = f3[1] ? SEL_REM : SEL_QUOT;
              side.dzero = (b == 32'd0);
            end
          endcase
        end else if (f7 != 7'd0 && f7 != 7'h20) begin
          ill = 1'b1;
        end else begin
          case ({f7[5], f3})
            4'd0: side.val = a + b;
            4'd8: side.val = a - b;
            4'd1: side.val = a << sh;
            4'd2: side.val = {31'd0, $signed(a) < $signed(b)};
            4'd3: side.val = {31'd0, a < b};
            4'd4: side.val = a ^ b;
            4'd5: side.val = a >> sh;
            4'd13: side.val = $unsigned($signed(a) >>> sh);
            4'd6: side.val = a | b;
            4'd7: side.val = a & b;
            default: ill = 1'b1;
          endcase
        end
        wr = !ill;
      end
      OP_SYSTEM: begin
        if (instruction == WORD_URET) begin
          side.sys = SYS_URET;
          side.npc = return_pc;
        end else if (instruction == WORD_ECALL) side.sys = SYS_ECALL;
        else side.sys = SYS_OTHER;
      end
      default: ill = 1'b1;
    endcase
    if (ill) begin
      wr = 1'b0;
      side.npc = pc;
      side.mkind = MEM_NONE;
      side.mwidth = 3'd0;
      side.maddr = 32'd0;
      side.sdata = 32'd0;
      side.sys = SYS_NONE;
      side.sel = SEL_DIRECT;
    end
    side.ill = ill;
    side.wr = wr && (instruction[11:7] != 5'd0);
    if (!side.wr) begin
      side.val = 32'd0;
      side.sel = SEL_DIRECT;
    end
    div_in.rem = 32'd0;
    div_in.quo = ua;
    div_in.dvs = ub;
  end

endmodule

FILE: rtl/core/rvx_div_cell.sv
// one restoring division step, registered
module rvx_div_cell (
  input  logic           clk,
  input  rvx_pkg::div_t  din,
  input  rvx_pkg::side_t side_in,
  output rvx_pkg::div_t  dout,
  output rvx_pkg::side_t side_out
);
  import rvx_pkg::*;

  logic [32:0] trial;
  logic [32:0] shifted;
  div_t        nxt;

  // shift in the next dividend bit and try to subtract
  always_comb begin
    shifted = {din.rem, din.quo[31]};
    trial = shifted - {1'b0, din.dvs};
    nxt.dvs = din.dvs;
    if (!trial[32]) begin
      nxt.rem = trial[31:0];
      nxt.quo = {din.quo[30:0], 1'b1};
    end else begin
      nxt.rem = shifted[31:0];
      nxt.quo = {din.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
    side_out <= side_in;
  end

endmodule

FILE: rtl/core/rvx_finish.sv
// multiplier stage and final result selection
module rvx_finish (
  input  logic           clk,
  input  rvx_pkg::side_t side_in,
  input  rvx_pkg::div_t  div_res,
  output logic [31:0]    value
);
  import rvx_pkg::*;

  logic [63:0] prod;
  side_t       s2;
  div_t        d2;
  logic [31:0] hi, q, r;

  // product registered before sign correction
  always_ff @(posedge clk) begin
    prod <= {32'd0, side_in.a} * {32'd0, side_in.b};
    s2 <= side_in;
    d2 <= div_res;
  end

  always_comb begin
    hi = prod[63:32] - (s2.hsub_a ? s2.b : 32'd0) - (s2.hsub_b ? s2.a : 32'd0);
    if (s2.dzero) q = 32'hffff_ffff;
    else if (s2.ovf) q = s2.a;
    else q = s2.neg_q ? -d2.quo : d2.quo;
    if (s2.dzero) r = s2.a;
    else if (s2.ovf) r = 32'd0;
    else r = s2.neg_r ? -d2.rem : d2.rem;
    case (s2.sel)
      SEL_MUL_LO: value = prod[31:0];
      SEL_MUL_HI: value = hi;
      SEL_QUOT:   value = q;
      SEL_REM:    value = r;
      default:    value = s2.val;
    endcase
  end

endmodule

FILE: rtl/core/rv32im_execute_unit.sv
// top level of the rv32im execute unit
// Usage: drive start with instruction, pc, rs1_value, rs2_value and
// return_pc; busy is always low, so one transaction is taken every cycle.
// Each transaction gives exactly one result, shown for one cycle with
// done high, in issue order. Every instruction passes through a chain of
// 32 division cells, one quotient bit each, then one register stage around
// the multiplier and one output register. Throughput is one instruction per
// cycle; the cell chain is fully pipelined.
// Reset (rst, synchronous) clears the valid bits of the chain so no
// result strobes until new transactions arrive. The receiver cannot
// stall; results must be taken in the cycle they appear.
// mem_kind, mem_width_code, mem_addr and store_data describe the memory
// request; sign extension of load data is done on the memory side.
module rv32im_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instruction,
  input  logic [31:0] pc,
  input  logic [31:0] rs1_value,
  input  logic [31:0] rs2_value,
  input  logic [31:0] return_pc,
  output logic        done,
  output logic        rd_write,
  output logic [4:0]  rd_index,
  output logic [31:0] rd_value,
  output logic [31:0] next_pc,
  output logic [1:0]  mem_kind,
  output logic [2:0]  mem_width_code,
  output logic [31:0] mem_addr,
  output logic [31:0] store_data,
  output logic        illegal,
  output logic [1:0]  system_kind
);
  import rvx_pkg::*;

  side_t side [DIV_CELLS+1];
  div_t  dv   [DIV_CELLS+1];
  logic [DIV_CELLS:0] vld;
  logic [31:0] value;
  side_t fin;

  assign busy = 1'b0;

  rvx_decode u_dec (
    .instruction(instruction), .pc(pc), .rs1_value(rs1_value),
    .rs2_value(rs2_value), .return_pc(return_pc),
    .side(side[0]), .div_in(dv[0])
  );

  // chain of division cells
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    rvx_div_cell u_cell (
      .clk(clk), .din(dv[i]), .side_in(side[i]),
      .dout(dv[i+1]), .side_out(side[i+1])
    );
  end

  rvx_finish u_fin (
    .clk(clk), .side_in(side[DIV_CELLS]), .div_res(dv[DIV_CELLS]), .value(value)
  );

  // valid bits follow the chain
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[DIV_CELLS-1:0], start};
  end

  // side data delayed to line up with finish stage
  always_ff @(posedge clk) fin <= side[DIV_CELLS];

  // output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld[DIV_CELLS];
    rd_write <= fin.wr;
    rd_index <= fin.rd;
    rd_value <= value;
    next_pc <= fin.npc;
    mem_kind <= fin.mkind;
    mem_width_code <= fin.mwidth;
    mem_addr <= fin.maddr;
    store_data <= fin.sdata;
    illegal <= fin.ill;
    system_kind <= fin.sys;
  end

endmodule

FILE: rtl/core/rvx_checker.sv
// port-level checker of the execute unit, bound to the top level
`include "assert_macros.svh"
module rvx_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       rd_write,
  input logic       illegal,
  input logic [1:0] mem_kind,
  input logic [1:0] system_kind
);
  import rvx_pkg::*;

  logic side_effect;
  logic bad_kind;

  // memory or system activity on a result
  assign side_effect = (mem_kind != MEM_NONE) || (system_kind != SYS_NONE);
  // memory kind outside the defined codes
  assign bad_kind = (mem_kind != MEM_NONE) && (mem_kind != MEM_LOAD) &&
                    (mem_kind != MEM_STORE);

  `CHK_ALWAYS(a_never_busy, clk, rst, !busy, "execute unit must never be busy")
  `CHK_ALWAYS(a_ill_nowrite, clk, rst, !(done && illegal && rd_write), "illegal with write")
  `CHK_ALWAYS(a_ill_quiet, clk, rst, !(done && illegal && side_effect), "illegal with side effect")
  `CHK_ALWAYS(a_kind_range, clk, rst, !(done && bad_kind), "bad mem kind")
  `CHK_NEXT(a_reset_quiet, clk, 1'b0, rst, !done, "done after reset")
endmodule

bind rv32im_execute_unit rvx_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .rd_write(rd_write), .illegal(illegal), .mem_kind(mem_kind),
  .system_kind(system_kind)
);

FILE: verif/testbench.sv
// self-checking testbench of the rv32im execute unit
`timescale 1ns / 1ps

module testbench;
  import rvx_pkg::*;

  // one instruction transaction as offered to the unit
  typedef struct packed {
    logic [31:0] insn;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] rpc;
  } insn_item_t;

  // one architectural outcome
  typedef struct packed {
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] npc;
    logic [1:0]  mkind;
    logic [2:0]  mwidth;
    logic [31:0] maddr;
    logic [31:0] sdata;
    logic        ill;
    logic [1:0]  sys;
  } outcome_t;

  typedef bit bool_t;

  localparam int LATENCY = 34;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] instruction;
  logic [31:0] pc;
  logic [31:0] rs1_value;
  logic [31:0] rs2_value;
  logic [31:0] return_pc;
  logic        done;
  logic        rd_write;
  logic [4:0]  rd_index;
  logic [31:0] rd_value;
  logic [31:0] next_pc;
  logic [1:0]  mem_kind;
  logic [2:0]  mem_width_code;
  logic [31:0] mem_addr;
  logic [31:0] store_data;
  logic        illegal;
  logic [1:0]  system_kind;

  insn_item_t pending_insns[$];
  outcome_t   expected_outcomes[$];
  int         error_count;
  bool_t      feed_done = 1'b0;
  int         gap_left;
  bit         hold_for_drain;
  int         drain_marker;

  rv32im_execute_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .instruction(instruction), .pc(pc), .rs1_value(rs1_value),
    .rs2_value(rs2_value), .return_pc(return_pc), .done(done),
    .rd_write(rd_write), .rd_index(rd_index), .rd_value(rd_value),
    .next_pc(next_pc), .mem_kind(mem_kind), .mem_width_code(mem_width_code),
    .mem_addr(mem_addr), .store_data(store_data), .illegal(illegal),
    .system_kind(system_kind)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // signed compare of two words
  function automatic bit less_signed(logic [31:0] x, logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // architectural result of one instruction
  function automatic outcome_t execute_insn(insn_item_t t);
    outcome_t    o;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi;
    logic [31:0] imm;
    logic [4:0]  sh;
    logic [63:0] prod;
    bit          cond;
    o = '0;
    opc = t.insn[6:0];
    f3 = t.insn[14:12];
    f7 = t.insn[31:25];
    immi = {{20{t.insn[31]}}, t.insn[31:20]};
    o.rd = t.insn[11:7];
    o.npc = t.pc + 32'd4;
    case (opc)
      OP_LUI: begin
        o.val = {t.insn[31:12], 12'd0}; o.wr = 1'b1;
      end
      OP_AUIPC: begin
        o.val = t.pc + {t.insn[31:12], 12'd0}; o.wr = 1'b1;
      end
      OP_JAL: begin
        imm = {{12{t.insn[31]}}, t.insn[19:12], t.insn[20], t.insn[30:21], 1'b0};
        o.val = t.pc + 32'd4; o.wr = 1'b1; o.npc = t.pc + imm;
      end
      OP_JALR: begin
        if (f3 != 3'd0) o.ill = 1'b1;
        else begin
          o.val = t.pc + 32'd4; o.wr = 1'b1;
          o.npc = (t.a + immi) & ~32'd1;
        end
      end
      OP_BRANCH: begin
        case (f3[2:1])
          2'd0: cond = t.a == t.b;
          2'd2: cond = less_signed(t.a, t.b);
          2'd3: cond = t.a < t.b;
          default: begin
            o.ill = 1'b1; cond = 1'b0;
          end
        endcase
        if (f3[0]) cond = ~cond;
        imm = {{20{t.insn[31]}}, t.insn[7], t.insn[30:25], t.insn[11:8], 1'b0};
        if (!o.ill && cond) o.npc = t.pc + imm;
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) o.ill = 1'b1;
        else begin
          o.mkind = MEM_LOAD; o.mwidth = f3; o.maddr = t.a + immi; o.wr = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 > 3'd2) o.ill = 1'b1;
        else begin
          o.mkind = MEM_STORE; o.mwidth = f3; o.sdata = t.b;
          o.maddr = t.a + {{20{t.insn[31]}}, t.insn[31:25], t.insn[11:7]};
        end
      end
      OP_IMM: begin
        sh = immi[4:0];
        case (f3)
          3'd0: o.val = t.a + immi;
          3'd1: if (f7 != 7'd0) o.ill = 1'b1; else o.val = t.a << sh;
          3'd2: o.val = {31'd0, less_signed(t.a, immi)};
          3'd3: o.val = {31'd0, t.a < immi};
          3'd4: o.val = t.a ^ immi;
          3'd5: begin
            if (f7 == 7'h00) o.val = t.a >> sh;
            else if (f7 == 7'h20) o.val = $unsigned($signed(t.a) >>> sh);
            else o.ill = 1'b1;
          end
          3'd6: o.val = t.a | immi;
          default: o.val = t.a & immi;
        endcase
        o.wr = ~o.ill;
      end
      OP_REG: begin
        sh = t.b[4:0];
        if (f7 == 7'h01) begin
          case (f3)
            3'd0: o.val = t.a * t.b;
            3'd1: begin
              prod = $signed({{32{t.a[31]}}, t.a}) * $signed({{32{t.b[31]}}, t.b});
              o.val = prod[63:32];
            end
            3'd2: begin
              prod = {{32{t.a[31]}}, t.a} * {32'd0, t.b};
              o.val = prod[63:32];
            end
            3'd3: begin
              prod = {32'd0, t.a} * {32'd0, t.b};
              o.val = prod[63:32];
            end
            3'd4: begin
              if (t.b == 0) o.val = '1;
              else if (t.a == 32'h8000_0000 && t.b == '1) o.val = t.a;
              else o.val = $signed(t.a) / $signed(t.b);
            end
            3'd5: o.val = (t.b == 0) ? '1 : t.a / t.b;
            3'd6: begin
              if (t.b == 0) o.val = t.a;
              else if (t.a == 32'h8000_0000 && t.b == '1) o.val = '0;
              else o.val = $signed(t.a) % $signed(t.b);
            end
            default: o.val = (t.b == 0) ? t.a : t.a % t.b;
          endcase
        end else if (f7 == 7'h00) begin
          case (f3)
            3'd0: o.val = t.a + t.b;
            3'd1: o.val = t.a << sh;
            3'd2: o.val = {31'd0, less_signed(t.a, t.b)};
            3'd3: o.val = {31'd0, t.a < t.b};
            3'd4: o.val = t.a ^ t.b;
            3'd5: o.val = t.a >> sh;
            3'd6: o.val = t.a | t.b;
            default: o.val = t.a & t.b;
          endcase
        end else if (f7 == 7'h20) begin
          case (f3)
            3'd0: o.val = t.a - t.b;
            3'd5: o.val = $unsigned($signed(t.a) >>> sh);
            default: o.ill = 1'b1;
          endcase
        end else o.ill = 1'b1;
        o.wr = ~o.ill;
      end
      OP_SYSTEM: begin
        if (t.insn == WORD_URET) begin
          o.sys = SYS_URET; o.npc = t.rpc;
        end else if (t.insn == WORD_ECALL) o.sys = SYS_ECALL;
        else o.sys = SYS_OTHER;
      end
      default: o.ill = 1'b1;
    endcase
    if (o.ill) begin
      o.wr = 1'b0; o.npc = t.pc; o.mkind = MEM_NONE; o.mwidth = '0;
      o.maddr = '0; o.sdata = '0; o.sys = SYS_NONE;
    end
    if (o.rd == 5'd0) o.wr = 1'b0;
    if (!o.wr) o.val = '0;
    return o;
  endfunction

  // operand value biased toward corner cases
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed instruction words with random fields
  function automatic logic [31:0] pick_insn();
    logic [31:0] w;
    logic [6:0]  ops[10];
    ops = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD, OP_STORE,
            OP_IMM, OP_REG, OP_SYSTEM};
    w = $urandom;
    case ($urandom_range(0, 19))
      0: ;
      1: w = WORD_ECALL;
      2: w = WORD_URET;
      3, 4, 5, 6: begin
        w[6:0] = OP_REG;
        case ($urandom_range(0, 3))
          0: w[31:25] = 7'h00;
          1: w[31:25] = 7'h20;
          default: w[31:25] = 7'h01;
        endcase
      end
      7, 8, 9: begin
        w[6:0] = OP_IMM;
        if ($urandom_range(0, 3) != 0) w[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h00;
      end
      default: w[6:0] = ops[$urandom_range(0, 9)];
    endcase
    return w;
  endfunction

  // queue one instruction transaction
  task automatic push_insn(logic [31:0] w, logic [31:0] x, logic [31:0] y);
    insn_item_t t;
    t.insn = w;
    t.pc = $urandom;
    t.a = x;
    t.b = y;
    t.rpc = $urandom;
    pending_insns.push_back(t);
  endtask

  // directed items then random ones
  initial begin
    // lui, auipc, jal, jalr and an illegal jalr
    push_insn(32'hfffff_0b7, 0, 0);
    push_insn(32'h12345_297, 0, 0);
    push_insn(32'h8000_00ef, 0, 0);
    push_insn(32'hfff0_8167, 32'h1001, 0);
    push_insn(32'h0000_9067, 1, 0);
    // branches taken and the undefined funct3
    push_insn(32'hfe20_8ee3, 5, 5);
    push_insn(32'h0020_c463, 32'h8000_0000, 1);
    push_insn(32'h0020_f463, 32'hffff_ffff, 1);
    push_insn(32'h0020_a463, 1, 2);
    // load, bad load width, store, bad store width
    push_insn(32'h8000_c283, 32'h10, 0);
    push_insn(32'h0000_b283, 0, 0);
    push_insn(32'hfe20_afa3, 32'h100, 32'hdead_beef);
    push_insn(32'h0020_b023, 0, 0);
    // arithmetic shift by 31, bad slli
    push_insn(32'h41f0_d293, 32'h8000_0000, 0);
    push_insn(32'h0200_9293, 1, 0);
    // division by zero, signed overflow, remainder forms and a signed mulh
    push_insn(32'h0220_c2b3, 32'h1234, 0);
    push_insn(32'h0220_c2b3, 32'h8000_0000, 32'hffff_ffff);
    push_insn(32'h0220_e2b3, 32'h8000_0000, 32'hffff_ffff);
    push_insn(32'h0220_f2b3, 7, 0);
    push_insn(32'h0220_92b3, 32'h8000_0000, 32'h8000_0000);
    // sub, bad funct7, undefined sub funct3, system words, unknown opcode
    push_insn(32'h4020_82b3, 3, 5);
    push_insn(32'h0420_82b3, 0, 0);
    push_insn(32'h4020_92b3, 0, 0);
    push_insn(WORD_ECALL, 0, 0);
    push_insn(WORD_URET, 0, 0);
    push_insn(32'h0010_0073, 0, 0);
    push_insn(32'hffff_ffff, 0, 0);
    repeat (1100) push_insn(pick_insn(), pick_operand(), pick_operand());
    feed_done = 1'b1;
  end

  // reset and input defaults
  initial begin
    error_count = 0;
    gap_left = 0;
    hold_for_drain = 1'b0;
    drain_marker = 600;
    rst = 1'b1;
    start = 1'b0;
    instruction = '0;
    pc = '0;
    rs1_value = '0;
    rs2_value = '0;
    return_pc = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: offer queued transactions with random gaps
  always @(posedge clk) begin
    insn_item_t t;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(execute_insn(
          '{instruction, pc, rs1_value, rs2_value, return_pc}));
      end
      if (start && busy) begin
        // keep offering the same transaction
      end else if (hold_for_drain) begin
        start <= 1'b0;
        if (expected_outcomes.size() == 0 && !(start && !busy)) hold_for_drain = 1'b0;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_insns.size() > 0) begin
        if (pending_insns.size() == drain_marker) begin
          drain_marker = -1;
          hold_for_drain = 1'b1;
          start <= 1'b0;
        end else begin
          t = pending_insns.pop_front();
          start <= 1'b1;
          instruction <= t.insn;
          pc <= t.pc;
          rs1_value <= t.a;
          rs2_value <= t.b;
          return_pc <= t.rpc;
          case ($urandom_range(0, 19))
            0, 1, 2: gap_left = $urandom_range(1, 3);
            3: gap_left = $urandom_range(10, 60);
            default: gap_left = 0;
          endcase
          if ((pending_insns.size() / 200) % 2 == 1) gap_left = 0;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare every strobed result with the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result transaction");
        error_count = error_count + 1;
      end else begin
        e = expected_outcomes.pop_front();
        if (rd_write !== e.wr) begin
          $error("rd_write exp %0h got %0h", e.wr, rd_write); error_count++;
        end
        if (rd_index !== e.rd) begin
          $error("rd_index exp %0h got %0h", e.rd, rd_index); error_count++;
        end
        if (rd_value !== e.val) begin
          $error("rd_value exp %0h got %0h", e.val, rd_value); error_count++;
        end
        if (next_pc !== e.npc) begin
          $error("next_pc exp %0h got %0h", e.npc, next_pc); error_count++;
        end
        if (mem_kind !== e.mkind) begin
          $error("mem_kind exp %0h got %0h", e.mkind, mem_kind); error_count++;
        end
        if (mem_width_code !== e.mwidth) begin
          $error("mem_width_code exp %0h got %0h", e.mwidth, mem_width_code);
          error_count++;
        end
        if (mem_addr !== e.maddr) begin
          $error("mem_addr exp %0h got %0h", e.maddr, mem_addr); error_count++;
        end
        if (store_data !== e.sdata) begin
          $error("store_data exp %0h got %0h", e.sdata, store_data); error_count++;
        end
        if (illegal !== e.ill) begin
          $error("illegal exp %0h got %0h", e.ill, illegal); error_count++;
        end
        if (system_kind !== e.sys) begin
          $error("system_kind exp %0h got %0h", e.sys, system_kind); error_count++;
        end
      end
    end
  end

  // end of run once all transactions are through
  initial begin
    wait (feed_done);
    @(posedge clk);
    while (pending_insns.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_outcomes.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
